[rtl/ptdec_pkg.sv]
`timescale 1ns / 1ps

package ptdec_pkg;

    // default geometry of the sheet
    localparam int TILE_WIDTH_DEFAULT   = 16;
    localparam int TILE_HEIGHT_DEFAULT  = 16;
    localparam int ADDRESS_BITS_DEFAULT = 20;

    // fixed field widths
    localparam int DATA_WIDTH          = 8;
    localparam int PIXEL_ADDRESS_WIDTH = 20;
    localparam int PIXEL_COLOR_WIDTH   = 32;
    localparam int COLUMN_WIDTH        = 8;
    localparam int ROW_WIDTH           = 12;
    localparam int Y_OFFSET_WIDTH      = 16;
    localparam int BYTE_COUNT_WIDTH    = 16;
    localparam int FILLER_WIDTH        = 4;
    localparam int PLANE_COUNT         = 4;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_VALUE_WIDTH = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPRITES_PER_ROW = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FILLER_SLOTS    = 8'd1;

    // register reset values
    localparam int SPRITES_PER_ROW_RESET = 52;
    localparam int FILLER_SLOTS_RESET    = 2;

    // 16-color palette, ARGB8888, indexed by {intensity, red, green, blue}
    localparam logic [PIXEL_COLOR_WIDTH-1:0] PALETTE [16] = '{
        32'hFF000000, 32'hFF0000AA, 32'hFF00AA00, 32'hFF00AAAA,
        32'hFFAA0000, 32'hFFAA00AA, 32'hFFAA5500, 32'hFFAAAAAA,
        32'hFF555555, 32'hFF5555FF, 32'hFF55FF55, 32'hFF55FFFF,
        32'hFFFF5555, 32'hFFFF55FF, 32'hFFFFFFAA, 32'hFFFFFFFF
    };

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_byte;
        logic                  file_start;
    } raw_item_t;

    typedef struct packed {
        logic [PIXEL_ADDRESS_WIDTH-1:0] pixel_address;
        logic [PIXEL_COLOR_WIDTH-1:0]   pixel_color;
        logic                           out_of_range;
        logic                           last_of_byte;
    } pixel_item_t;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_WIDTH,
        PH_HEIGHT,
        PH_DATA,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic [ROW_WIDTH-1:0]    row;
        logic [COLUMN_WIDTH-1:0] col;
    } slot_t;

    // step to the next grid slot, wrapping the column at the row length
    function automatic slot_t slot_advance(slot_t cur, logic [COLUMN_WIDTH-1:0] spr);
        logic [COLUMN_WIDTH:0] n;
        logic [COLUMN_WIDTH:0] nxt;
        slot_t                 res;
        n   = (spr == '0) ? (COLUMN_WIDTH+1)'(1) : {1'b0, spr};
        nxt = {1'b0, cur.col} + (COLUMN_WIDTH+1)'(1);
        if (nxt >= n) begin
            res.col = '0;
            res.row = cur.row + ROW_WIDTH'(1);
        end
        else begin
            res.col = nxt[COLUMN_WIDTH-1:0];
            res.row = cur.row;
        end
        return res;
    endfunction

endpackage

[rtl/planar_tile_sheet_decoder_unit.sv]
`timescale 1ns / 1ps

// Planar tile sheet decoder. Takes a sprite file one byte per request: a
// three-byte group header (sprite count, width in plane bytes, height in rows)
// and then runs of five plane bytes (transparency, blue, green, red,
// intensity). Each run gives eight pixel requests with sheet address and ARGB
// color, one per cycle unless the output stalls, from a single pixel emitter;
// the fifth byte starts the emitter, and each pixel then passes through the
// registered stages p1, p2 and p3 to the output. Header and the first four
// plane bytes of a run are taken one per cycle, also while the emitter is
// busy; the fifth byte of a run waits until the emitter is on the last pixel
// of the run before. After the last run of a nonempty group the slot index
// steps over the filler slots one per cycle, and while it does, neither input
// bytes nor register writes are taken. No clearing pass after reset.
module planar_tile_sheet_decoder_unit #(
    parameter int TILE_WIDTH   = ptdec_pkg::TILE_WIDTH_DEFAULT,
    parameter int TILE_HEIGHT  = ptdec_pkg::TILE_HEIGHT_DEFAULT,
    parameter int ADDRESS_BITS = ptdec_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     raw_valid,
    output logic                                     raw_ready,
    input  ptdec_pkg::raw_item_t                     raw_item,
    output logic                                     pix_valid,
    input  logic                                     pix_ready,
    output ptdec_pkg::pixel_item_t                   pix_item,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [ptdec_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [ptdec_pkg::CFG_VALUE_WIDTH-1:0]    cfg_value
);

    import ptdec_pkg::*;

    // derived widths
    localparam int XW  = $clog2(TILE_WIDTH);
    localparam int PXW = COLUMN_WIDTH + $clog2(TILE_WIDTH);
    localparam int SWW = PXW;
    localparam int PYW = ROW_WIDTH + $clog2(TILE_HEIGHT) + 2;
    localparam int PW  = PYW + SWW;
    localparam int AW  = PW + 1;

    // configuration registers
    logic [COLUMN_WIDTH-1:0] spr_reg;
    logic [FILLER_WIDTH-1:0] filler_reg;
    logic [SWW-1:0]          sheet_w_reg;

    // parser state
    phase_t                      phase_reg, phase_next;
    logic [DATA_WIDTH-1:0]       count_reg, count_next;
    logic [DATA_WIDTH-1:0]       width_reg, width_next;
    logic [BYTE_COUNT_WIDTH-1:0] wh_reg, wh_next;
    logic [DATA_WIDTH-1:0]       sprite_reg, sprite_next;
    logic [BYTE_COUNT_WIDTH-1:0] byte_cnt_reg, byte_cnt_next;
    logic [2:0]                  pos_reg, pos_next;
    logic [COLUMN_WIDTH-1:0]     col_reg, col_next;
    logic [ROW_WIDTH-1:0]        row_reg, row_next;
    logic [XW-1:0]               x_reg, x_next;
    logic [Y_OFFSET_WIDTH-1:0]   y_reg, y_next;
    logic [FILLER_WIDTH-1:0]     skip_reg, skip_next;
    logic [DATA_WIDTH-1:0]       planes_reg [PLANE_COUNT];

    // emitter state
    logic                      em_valid_reg;
    logic [2:0]                em_bit_reg;
    logic [DATA_WIDTH-1:0]     em_t_reg, em_b_reg, em_g_reg, em_r_reg, em_i_reg;
    logic [COLUMN_WIDTH-1:0]   em_col_reg;
    logic [ROW_WIDTH-1:0]      em_row_reg;
    logic [XW-1:0]             em_x_reg;
    logic [Y_OFFSET_WIDTH-1:0] em_y_reg;

    // address pipeline
    logic                         p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic [PXW-1:0]               p1_px_reg, p2_px_reg;
    logic [PYW-1:0]               p1_py_reg;
    logic [PW-1:0]                p2_prod_reg;
    logic [PIXEL_COLOR_WIDTH-1:0] p1_color_reg, p2_color_reg;
    logic                         p1_last_reg, p2_last_reg;
    pixel_item_t                  p3_item_reg;

    logic                         raw_fire;
    logic                         launch;
    logic                         plane_write;
    logic                         adv;
    logic                         em_free;
    slot_t                        slot_adv;
    logic [XW:0]                  x8;
    logic [XW:0]                  em_x1;
    logic [3:0]                   color_idx;
    logic [PIXEL_COLOR_WIDTH-1:0] color;
    logic [PXW-1:0]               px;
    logic [PYW-1:0]               py;
    logic [AW-1:0]                addr;
    logic [COLUMN_WIDTH-1:0]      spr_eff;

    // handshakes
    assign adv       = !p3_valid_reg || pix_ready;
    assign em_free   = !em_valid_reg || (em_bit_reg == 3'd0 && adv);
    assign raw_ready = (phase_reg != PH_SKIP)
                       && (!(phase_reg == PH_DATA && pos_reg == 3'd4) || em_free);
    assign cfg_ready = (phase_reg != PH_SKIP);
    assign raw_fire  = raw_valid && raw_ready;
    assign launch    = raw_fire && !raw_item.file_start
                       && phase_reg == PH_DATA && pos_reg == 3'd4;
    assign plane_write = raw_fire && !raw_item.file_start
                         && phase_reg == PH_DATA && pos_reg != 3'd4;

    // configuration writes
    assign spr_eff = (cfg_value[COLUMN_WIDTH-1:0] == '0) ? COLUMN_WIDTH'(1)
                                                         : cfg_value[COLUMN_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg     <= COLUMN_WIDTH'(SPRITES_PER_ROW_RESET);
            filler_reg  <= FILLER_WIDTH'(FILLER_SLOTS_RESET);
            sheet_w_reg <= SWW'(SPRITES_PER_ROW_RESET * TILE_WIDTH);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_SPRITES_PER_ROW)
            begin
                spr_reg     <= cfg_value[COLUMN_WIDTH-1:0];
                sheet_w_reg <= SWW'(spr_eff) * SWW'(TILE_WIDTH);
            end
            else if (cfg_index == CFG_FILLER_SLOTS)
            begin
                filler_reg <= cfg_value[FILLER_WIDTH-1:0];
            end
        end
    end

    // parser next state
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        width_next    = width_reg;
        wh_next       = wh_reg;
        sprite_next   = sprite_reg;
        byte_cnt_next = byte_cnt_reg;
        pos_next      = pos_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        skip_next     = skip_reg;
        slot_adv      = slot_advance('{row: row_reg, col: col_reg}, spr_reg);
        x8            = {1'b0, x_reg} + (XW+1)'(8);

        unique case (phase_reg)
            PH_SKIP:
            begin
                col_next  = slot_adv.col;
                row_next  = slot_adv.row;
                skip_next = skip_reg - FILLER_WIDTH'(1);
                if (skip_reg == FILLER_WIDTH'(1))
                begin
                    phase_next = PH_COUNT;
                end
            end
            default:
            begin
                if (raw_fire && raw_item.file_start)
                begin
                    // new file: clear parser and slot index, byte is header byte zero
                    count_next    = raw_item.data_byte;
                    phase_next    = PH_WIDTH;
                    col_next      = '0;
                    row_next      = '0;
                    sprite_next   = '0;
                    byte_cnt_next = '0;
                    pos_next      = '0;
                    x_next        = '0;
                    y_next        = '0;
                end
                else if (raw_fire)
                begin
                    unique case (phase_reg)
                        PH_COUNT:
                        begin
                            count_next = raw_item.data_byte;
                            phase_next = PH_WIDTH;
                        end
                        PH_WIDTH:
                        begin
                            width_next = raw_item.data_byte;
                            phase_next = PH_HEIGHT;
                        end
                        PH_HEIGHT:
                        begin
                            wh_next = BYTE_COUNT_WIDTH'(width_reg)
                                      * BYTE_COUNT_WIDTH'(raw_item.data_byte);
                            if (count_reg == '0 || width_reg == '0
                                || raw_item.data_byte == '0)
                            begin
                                phase_next = PH_COUNT;
                            end
                            else
                            begin
                                phase_next    = PH_DATA;
                                sprite_next   = '0;
                                byte_cnt_next = '0;
                                pos_next      = '0;
                                x_next        = '0;
                                y_next        = '0;
                            end
                        end
                        default:
                        begin
                            if (pos_reg != 3'd4)
                            begin
                                pos_next = pos_reg + 3'd1;
                            end
                            else
                            begin
                                // run complete: pixel walk moves on by eight
                                pos_next = '0;
                                if (x8 >= (XW+1)'(TILE_WIDTH))
                                begin
                                    x_next = XW'(x8 - (XW+1)'(TILE_WIDTH));
                                    y_next = y_reg + Y_OFFSET_WIDTH'(1);
                                end
                                else
                                begin
                                    x_next = x8[XW-1:0];
                                end
                                // sprite and group end
                                if ({1'b0, byte_cnt_reg} + (BYTE_COUNT_WIDTH+1)'(1)
                                    >= {1'b0, wh_reg})
                                begin
                                    byte_cnt_next = '0;
                                    x_next        = '0;
                                    y_next        = '0;
                                    col_next      = slot_adv.col;
                                    row_next      = slot_adv.row;
                                    if ({1'b0, sprite_reg} + (DATA_WIDTH+1)'(1)
                                        >= {1'b0, count_reg})
                                    begin
                                        sprite_next = '0;
                                        if (filler_reg != '0)
                                        begin
                                            phase_next = PH_SKIP;
                                            skip_next  = filler_reg;
                                        end
                                        else
                                        begin
                                            phase_next = PH_COUNT;
                                        end
                                    end
                                    else
                                    begin
                                        sprite_next = sprite_reg + DATA_WIDTH'(1);
                                    end
                                end
                                else
                                begin
                                    byte_cnt_next = byte_cnt_reg + BYTE_COUNT_WIDTH'(1);
                                end
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COUNT;
            count_reg    <= '0;
            width_reg    <= '0;
            wh_reg       <= '0;
            sprite_reg   <= '0;
            byte_cnt_reg <= '0;
            pos_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            skip_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            width_reg    <= width_next;
            wh_reg       <= wh_next;
            sprite_reg   <= sprite_next;
            byte_cnt_reg <= byte_cnt_next;
            pos_reg      <= pos_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            skip_reg     <= skip_next;
        end
    end

    // first four plane bytes of a run
    always_ff @(posedge clk)
    begin
        if (plane_write)
        begin
            planes_reg[pos_reg[1:0]] <= raw_item.data_byte;
        end
    end

    // emitter control: eight pixels per run, bit 7 first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            em_bit_reg   <= '0;
        end
        else if (launch)
        begin
            em_valid_reg <= 1'b1;
            em_bit_reg   <= 3'd7;
        end
        else if (em_valid_reg && adv)
        begin
            if (em_bit_reg == 3'd0)
            begin
                em_valid_reg <= 1'b0;
            end
            else
            begin
                em_bit_reg <= em_bit_reg - 3'd1;
            end
        end
    end

    // emitter payload and per-pixel walk
    assign em_x1 = {1'b0, em_x_reg} + (XW+1)'(1);

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            em_t_reg   <= planes_reg[0];
            em_b_reg   <= planes_reg[1];
            em_g_reg   <= planes_reg[2];
            em_r_reg   <= planes_reg[3];
            em_i_reg   <= raw_item.data_byte;
            em_col_reg <= col_reg;
            em_row_reg <= row_reg;
            em_x_reg   <= x_reg;
            em_y_reg   <= y_reg;
        end
        else if (em_valid_reg && adv)
        begin
            if (em_x1 >= (XW+1)'(TILE_WIDTH))
            begin
                em_x_reg <= '0;
                em_y_reg <= em_y_reg + Y_OFFSET_WIDTH'(1);
            end
            else
            begin
                em_x_reg <= em_x1[XW-1:0];
            end
        end
    end

    // pixel color and sheet coordinates
    assign color_idx = {em_i_reg[em_bit_reg], em_r_reg[em_bit_reg],
                        em_g_reg[em_bit_reg], em_b_reg[em_bit_reg]};
    assign color     = em_t_reg[em_bit_reg] ? PALETTE[color_idx] : '0;
    assign px        = PXW'(em_col_reg) * PXW'(TILE_WIDTH) + PXW'(em_x_reg);
    assign py        = PYW'(em_row_reg) * PYW'(TILE_HEIGHT) + PYW'(em_y_reg);
    assign addr      = AW'(p2_prod_reg) + AW'(p2_px_reg);

    // pipeline valids, all stages move together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= em_valid_reg;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // pipeline payload: coordinates, row product, final address
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_px_reg                 <= px;
            p1_py_reg                 <= py;
            p1_color_reg              <= color;
            p1_last_reg               <= (em_bit_reg == 3'd0);
            p2_px_reg                 <= p1_px_reg;
            p2_prod_reg               <= PW'(p1_py_reg) * PW'(sheet_w_reg);
            p2_color_reg              <= p1_color_reg;
            p2_last_reg               <= p1_last_reg;
            p3_item_reg.pixel_address <= addr[PIXEL_ADDRESS_WIDTH-1:0];
            p3_item_reg.pixel_color   <= p2_color_reg;
            p3_item_reg.out_of_range  <= ((addr >> ADDRESS_BITS) != '0);
            p3_item_reg.last_of_byte  <= p2_last_reg;
        end
    end

    assign pix_valid = p3_valid_reg;
    assign pix_item  = p3_item_reg;

    // a new run only enters when the emitter is free
    a_launch_free: assert property (@(posedge clk) disable iff (!rst_n)
        launch |-> (!em_valid_reg || (em_bit_reg == 3'd0 && adv)))
        else $error("run launched while emitter busy");

    // emitter walks the bits down one per advancing cycle
    a_em_count: assert property (@(posedge clk) disable iff (!rst_n)
        (em_valid_reg && adv && em_bit_reg != 3'd0 && !launch)
        |=> (em_valid_reg && em_bit_reg == $past(em_bit_reg) - 3'd1))
        else $error("emitter bit count skipped");

    // pixel walk column stays inside the tile
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(x_reg) < TILE_WIDTH) && (!em_valid_reg || 32'(em_x_reg) < TILE_WIDTH))
        else $error("x offset outside tile");

    // plane position never passes the fifth byte
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg <= 3'd4) && (pos_reg == 3'd0 || phase_reg == PH_DATA))
        else $error("plane position out of range");

endmodule
